@@ hw/rtl/efflx_pkg.sv @@
// Package for the Euler face flux block: word widths, fixed-point constants,
// shared types and the saturating fixed-point helper functions.
// Depends on nothing; used by efflx_div and euler_face_flux_top.
`default_nettype none

package efflx_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int HEAT_BITS = 18;
    localparam logic [HEAT_BITS-1:0] HEAT_RESET = 18'd91750;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t FX_ONE  = word_t'(1) << FRAC_BITS;
    localparam word_t FX_HALF = word_t'(1) << (FRAC_BITS - 1);
    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // A word together with its overflow flag.
    typedef struct packed {
        word_t val;
        logic  sat;
    } sword_t;

    // Sign and unsigned magnitude of a full product.
    typedef struct packed {
        logic                 neg;
        logic [PROD_BITS-1:0] mag;
    } prod_t;

    // Cell data that travels alongside the divider.
    typedef struct packed {
        logic  vld;
        logic  bad;
        word_t rho;
        word_t en;
        word_t nx;
        word_t ny;
        word_t area;
    } side_t;

    function automatic logic [WORD_BITS-1:0] mag_of(word_t a);
        logic [WORD_BITS-1:0] ua;
        ua = a;
        return a[WORD_BITS-1] ? (~ua + 1'b1) : ua;
    endfunction

    // Signed word from a magnitude, clipped to the word range.
    function automatic sword_t pack_mag(logic neg, logic [PROD_BITS-1:0] m);
        logic [PROD_BITS-1:0] lim;
        logic [PROD_BITS-1:0] mm;
        logic [WORD_BITS-1:0] lo;
        sword_t               r;
        lim   = {{(PROD_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}}
                + PROD_BITS'(neg);
        r.sat = (m > lim);
        mm    = r.sat ? lim : m;
        lo    = mm[WORD_BITS-1:0];
        r.val = neg ? word_t'(~lo + 1'b1) : word_t'(lo);
        return r;
    endfunction

    function automatic prod_t mul_start(word_t a, word_t b);
        logic [WORD_BITS-1:0] ma;
        logic [WORD_BITS-1:0] mb;
        prod_t                p;
        ma    = mag_of(a);
        mb    = mag_of(b);
        p.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        p.mag = {{(PROD_BITS-WORD_BITS){1'b0}}, ma} * {{(PROD_BITS-WORD_BITS){1'b0}}, mb};
        return p;
    endfunction

    // Round to nearest on the magnitude, ties away from zero.
    function automatic sword_t mul_end(prod_t p);
        logic [PROD_BITS:0] s;
        s = {1'b0, p.mag} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1));
        return pack_mag(p.neg, PROD_BITS'(s >> FRAC_BITS));
    endfunction

    function automatic sword_t add_sat(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        sword_t             r;
        s     = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.sat = s[WORD_BITS] != s[WORD_BITS-1];
        r.val = r.sat ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
        return r;
    endfunction

    function automatic sword_t sub_sat(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        sword_t             r;
        s     = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.sat = s[WORD_BITS] != s[WORD_BITS-1];
        r.val = r.sat ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/efflx_div.sv @@
// Pipelined restoring divider: two quotients (|a| << FRAC_BITS) / rho, one
// quotient bit per stage, with the cell data carried alongside.
// Depends on efflx_pkg.
`default_nettype none

module efflx_div
    import efflx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire side_t                side_in,
    input  wire word_t                num_a,
    input  wire word_t                num_b,
    output side_t                     side_out,
    output logic [QUOT_BITS-1:0]      quo_a,
    output logic [QUOT_BITS-1:0]      quo_b,
    output logic                      neg_a,
    output logic                      neg_b
);

    localparam int NQ = QUOT_BITS;

    side_t                sd_reg [0:NQ];
    logic [WORD_BITS-1:0] ra_reg [0:NQ];
    logic [WORD_BITS-1:0] rb_reg [0:NQ];
    logic [NQ-1:0]        sa_reg [0:NQ];
    logic [NQ-1:0]        sb_reg [0:NQ];
    logic [NQ-1:0]        qa_reg [0:NQ];
    logic [NQ-1:0]        qb_reg [0:NQ];
    logic                 na_reg [0:NQ];
    logic                 nb_reg [0:NQ];

    // Entry point of the chain is the unregistered input.
    assign sd_reg[0] = side_in;
    assign ra_reg[0] = '0;
    assign rb_reg[0] = '0;
    assign sa_reg[0] = {mag_of(num_a), {FRAC_BITS{1'b0}}};
    assign sb_reg[0] = {mag_of(num_b), {FRAC_BITS{1'b0}}};
    assign qa_reg[0] = '0;
    assign qb_reg[0] = '0;
    assign na_reg[0] = num_a[WORD_BITS-1];
    assign nb_reg[0] = num_b[WORD_BITS-1];

    for (genvar g = 0; g < NQ; g++) begin : g_stage
        logic [WORD_BITS:0]   ta;
        logic [WORD_BITS:0]   tb;
        logic [WORD_BITS:0]   dv;
        logic                 ga;
        logic                 gb;

        assign dv = {1'b0, sd_reg[g].rho};
        assign ta = {ra_reg[g], sa_reg[g][NQ-1]};
        assign tb = {rb_reg[g], sb_reg[g][NQ-1]};
        assign ga = ta >= dv;
        assign gb = tb >= dv;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sd_reg[g+1] <= '0;
            end
            else
            begin
                sd_reg[g+1] <= sd_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            ra_reg[g+1] <= ga ? WORD_BITS'(ta - dv) : ta[WORD_BITS-1:0];
            rb_reg[g+1] <= gb ? WORD_BITS'(tb - dv) : tb[WORD_BITS-1:0];
            sa_reg[g+1] <= sa_reg[g] << 1;
            sb_reg[g+1] <= sb_reg[g] << 1;
            qa_reg[g+1] <= {qa_reg[g][NQ-2:0], ga};
            qb_reg[g+1] <= {qb_reg[g][NQ-2:0], gb};
            na_reg[g+1] <= na_reg[g];
            nb_reg[g+1] <= nb_reg[g];
        end
    end

    assign side_out = sd_reg[NQ];
    assign quo_a    = qa_reg[NQ];
    assign quo_b    = qb_reg[NQ];
    assign neg_a    = na_reg[NQ];
    assign neg_b    = nb_reg[NQ];

endmodule

`default_nettype wire

@@ hw/rtl/euler_face_flux_top.sv @@
// Top level of the Euler face flux block: command port, APB register port,
// and the flux pipeline that follows the divider.
// Depends on efflx_pkg and efflx_div.
`default_nettype none

// This block computes the physical flux of the 2D Euler equations through one
// face per item, in Q16.16 fixed point. It never stalls: busy is always low,
// so a new face may be started in every clock cycle, and each face produces
// exactly one result beat. Each face passes through the 48-stage restoring
// divider that forms the velocities (one quotient bit per stage), followed
// by 16 arithmetic stages and one output register.
// Results appear on the flux ports for a single cycle, marked by done, and
// the receiver cannot hold them off, so it must take every beat as it comes.
// A face with density of zero or below returns bad_density set, all fluxes
// zero and saturated clear. Any clip of an intermediate or final value sets
// saturated. The heat ratio register lies at byte address 0 of the APB port
// and may only be written while no face is in flight.

module euler_face_flux_top
    import efflx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [31:0]    density,
    input  wire logic signed [31:0]    momentum_x,
    input  wire logic signed [31:0]    momentum_y,
    input  wire logic signed [31:0]    total_energy,
    input  wire logic signed [17:0]    normal_x,
    input  wire logic signed [17:0]    normal_y,
    input  wire logic        [30:0]    face_area,
    output logic                       done,
    output logic signed [31:0]         mass_flux,
    output logic signed [31:0]         xmom_flux,
    output logic signed [31:0]         ymom_flux,
    output logic signed [31:0]         energy_flux,
    output logic                       bad_density,
    output logic                       saturated,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int NST       = 16;
    localparam int NW        = 16;
    localparam int NP        = 6;
    localparam int SLOT_BITS = 4;

    // Word slots in the stage record. Temporaries are reused once dead.
    localparam logic [SLOT_BITS-1:0] W_RHO  = 4'd0;
    localparam logic [SLOT_BITS-1:0] W_EN   = 4'd1;
    localparam logic [SLOT_BITS-1:0] W_NX   = 4'd2;
    localparam logic [SLOT_BITS-1:0] W_NY   = 4'd3;
    localparam logic [SLOT_BITS-1:0] W_AREA = 4'd4;
    localparam logic [SLOT_BITS-1:0] W_GM1  = 4'd5;
    localparam logic [SLOT_BITS-1:0] W_U    = 4'd6;
    localparam logic [SLOT_BITS-1:0] W_V    = 4'd7;
    localparam logic [SLOT_BITS-1:0] W_T0   = 4'd8;
    localparam logic [SLOT_BITS-1:0] W_T1   = 4'd9;
    localparam logic [SLOT_BITS-1:0] W_UN   = 4'd10;
    localparam logic [SLOT_BITS-1:0] W_T3   = 4'd11;
    localparam logic [SLOT_BITS-1:0] W_SX   = 4'd12;
    localparam logic [SLOT_BITS-1:0] W_SY   = 4'd13;
    localparam logic [SLOT_BITS-1:0] W_PX   = 4'd14;
    localparam logic [SLOT_BITS-1:0] W_PY   = 4'd15;

    typedef struct packed {
        logic               vld;
        logic               bad;
        logic               sat;
        word_t [NW-1:0]     w;
        prod_t [NP-1:0]     p;
    } stage_t;

    // Store a word into a slot and fold in its overflow flag.
    function automatic stage_t put(stage_t s, logic [SLOT_BITS-1:0] idx, sword_t r);
        stage_t t;
        t        = s;
        t.w[idx] = r.val;
        t.sat    = s.sat | r.sat;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [HEAT_BITS-1:0] heat_ratio_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_ratio_reg <= HEAT_RESET;
        end
        else if (cfg_wr && !paddr[2])
        begin
            heat_ratio_reg <= pwdata[HEAT_BITS-1:0];
        end
    end

    assign prdata = paddr[2] ? '0 : {{(32-HEAT_BITS){1'b0}}, heat_ratio_reg};

    // ------------------------------------------------------------------
    // Divider front end: u = mx / rho and v = my / rho.
    // ------------------------------------------------------------------
    side_t                side_in;
    side_t                dv_side;
    logic [QUOT_BITS-1:0] quo_u;
    logic [QUOT_BITS-1:0] quo_v;
    logic                 neg_u;
    logic                 neg_v;

    assign busy = 1'b0;

    always_comb
    begin
        side_in.vld  = start && !busy;
        side_in.bad  = density <= 0;
        side_in.rho  = word_t'(density);
        side_in.en   = word_t'(total_energy);
        side_in.nx   = word_t'(normal_x);
        side_in.ny   = word_t'(normal_y);
        side_in.area = word_t'({1'b0, face_area});
    end

    efflx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (side_in),
        .num_a    (word_t'(momentum_x)),
        .num_b    (word_t'(momentum_y)),
        .side_out (dv_side),
        .quo_a    (quo_u),
        .quo_b    (quo_v),
        .neg_a    (neg_u),
        .neg_b    (neg_v)
    );

    // ------------------------------------------------------------------
    // Flux pipeline. Each multiply takes two stages: magnitude product,
    // then rounding and clipping. Adds take one stage.
    // ------------------------------------------------------------------
    stage_t st_reg  [0:NST-1];
    stage_t st_next [0:NST-1];

    always_comb
    begin
        stage_t s;

        // Stage 0: clip the quotients, load the cell data, form gamma - 1.
        s          = '0;
        s.vld      = dv_side.vld;
        s.bad      = dv_side.bad;
        s.w[W_RHO] = dv_side.rho;
        s.w[W_EN]  = dv_side.en;
        s.w[W_NX]  = dv_side.nx;
        s.w[W_NY]  = dv_side.ny;
        s.w[W_AREA] = dv_side.area;
        s = put(s, W_U, pack_mag(neg_u, PROD_BITS'(quo_u)));
        s = put(s, W_V, pack_mag(neg_v, PROD_BITS'(quo_v)));
        s = put(s, W_GM1, sub_sat(word_t'({{(WORD_BITS-HEAT_BITS){1'b0}}, heat_ratio_reg}),
                                  FX_ONE));
        st_next[0] = s;

        for (int k = 1; k < NST; k++)
        begin
            st_next[k] = st_reg[k-1];
        end

        // Stage 1: u*u, v*v, u*nx, v*ny, rho*u, rho*v.
        st_next[1].p[0] = mul_start(st_reg[0].w[W_U], st_reg[0].w[W_U]);
        st_next[1].p[1] = mul_start(st_reg[0].w[W_V], st_reg[0].w[W_V]);
        st_next[1].p[2] = mul_start(st_reg[0].w[W_U], st_reg[0].w[W_NX]);
        st_next[1].p[3] = mul_start(st_reg[0].w[W_V], st_reg[0].w[W_NY]);
        st_next[1].p[4] = mul_start(st_reg[0].w[W_RHO], st_reg[0].w[W_U]);
        st_next[1].p[5] = mul_start(st_reg[0].w[W_RHO], st_reg[0].w[W_V]);

        st_next[2] = put(st_next[2], W_T0, mul_end(st_reg[1].p[0]));
        st_next[2] = put(st_next[2], W_T1, mul_end(st_reg[1].p[1]));
        st_next[2] = put(st_next[2], W_UN, mul_end(st_reg[1].p[2]));
        st_next[2] = put(st_next[2], W_T3, mul_end(st_reg[1].p[3]));
        st_next[2] = put(st_next[2], W_SX, mul_end(st_reg[1].p[4]));
        st_next[2] = put(st_next[2], W_SY, mul_end(st_reg[1].p[5]));

        // Stage 3: q = u*u + v*v and un = u*nx + v*ny.
        st_next[3] = put(st_next[3], W_T0, add_sat(st_reg[2].w[W_T0], st_reg[2].w[W_T1]));
        st_next[3] = put(st_next[3], W_UN, add_sat(st_reg[2].w[W_UN], st_reg[2].w[W_T3]));

        // Stage 4: rho*q, rho*un, (rho u)*un, (rho v)*un.
        st_next[4].p[0] = mul_start(st_reg[3].w[W_RHO], st_reg[3].w[W_T0]);
        st_next[4].p[1] = mul_start(st_reg[3].w[W_RHO], st_reg[3].w[W_UN]);
        st_next[4].p[2] = mul_start(st_reg[3].w[W_SX], st_reg[3].w[W_UN]);
        st_next[4].p[3] = mul_start(st_reg[3].w[W_SY], st_reg[3].w[W_UN]);

        st_next[5] = put(st_next[5], W_T0, mul_end(st_reg[4].p[0]));
        st_next[5] = put(st_next[5], W_T1, mul_end(st_reg[4].p[1]));
        st_next[5] = put(st_next[5], W_SX, mul_end(st_reg[4].p[2]));
        st_next[5] = put(st_next[5], W_SY, mul_end(st_reg[4].p[3]));

        // Stages 6 to 8: kinetic energy and the internal energy difference.
        st_next[6].p[0] = mul_start(FX_HALF, st_reg[5].w[W_T0]);
        st_next[7] = put(st_next[7], W_T0, mul_end(st_reg[6].p[0]));
        st_next[8] = put(st_next[8], W_T0, sub_sat(st_reg[7].w[W_EN], st_reg[7].w[W_T0]));

        // Stages 9 and 10: pressure.
        st_next[9].p[0] = mul_start(st_reg[8].w[W_GM1], st_reg[8].w[W_T0]);
        st_next[10] = put(st_next[10], W_T0, mul_end(st_reg[9].p[0]));

        // Stage 11: p*nx, p*ny and E + p.
        st_next[11].p[0] = mul_start(st_reg[10].w[W_T0], st_reg[10].w[W_NX]);
        st_next[11].p[1] = mul_start(st_reg[10].w[W_T0], st_reg[10].w[W_NY]);
        st_next[11] = put(st_next[11], W_T3, add_sat(st_reg[10].w[W_EN], st_reg[10].w[W_T0]));

        st_next[12] = put(st_next[12], W_PX, mul_end(st_reg[11].p[0]));
        st_next[12] = put(st_next[12], W_PY, mul_end(st_reg[11].p[1]));

        // Stage 13: momentum flux sums and (E + p)*un.
        st_next[13] = put(st_next[13], W_SX, add_sat(st_reg[12].w[W_SX], st_reg[12].w[W_PX]));
        st_next[13] = put(st_next[13], W_SY, add_sat(st_reg[12].w[W_SY], st_reg[12].w[W_PY]));
        st_next[13].p[2] = mul_start(st_reg[12].w[W_T3], st_reg[12].w[W_UN]);

        st_next[14] = put(st_next[14], W_T3, mul_end(st_reg[13].p[2]));

        // Stage 15: scale all four fluxes by the face area.
        st_next[15].p[0] = mul_start(st_reg[14].w[W_AREA], st_reg[14].w[W_T1]);
        st_next[15].p[1] = mul_start(st_reg[14].w[W_AREA], st_reg[14].w[W_SX]);
        st_next[15].p[2] = mul_start(st_reg[14].w[W_AREA], st_reg[14].w[W_SY]);
        st_next[15].p[3] = mul_start(st_reg[14].w[W_AREA], st_reg[14].w[W_T3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                st_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: final rounding, flags and the bad density override.
    // ------------------------------------------------------------------
    logic                 done_reg;
    logic                 done_next;
    word_t                mass_reg, xmom_reg, ymom_reg, energy_reg;
    word_t                mass_next, xmom_next, ymom_next, energy_next;
    logic                 bad_reg, bad_next;
    logic                 sat_reg, sat_next;

    always_comb
    begin
        sword_t f0;
        sword_t f1;
        sword_t f2;
        sword_t f3;
        f0 = mul_end(st_reg[NST-1].p[0]);
        f1 = mul_end(st_reg[NST-1].p[1]);
        f2 = mul_end(st_reg[NST-1].p[2]);
        f3 = mul_end(st_reg[NST-1].p[3]);
        done_next = st_reg[NST-1].vld;
        bad_next  = st_reg[NST-1].bad;
        if (st_reg[NST-1].bad)
        begin
            mass_next   = '0;
            xmom_next   = '0;
            ymom_next   = '0;
            energy_next = '0;
            sat_next    = 1'b0;
        end
        else
        begin
            mass_next   = f0.val;
            xmom_next   = f1.val;
            ymom_next   = f2.val;
            energy_next = f3.val;
            sat_next    = st_reg[NST-1].sat | f0.sat | f1.sat | f2.sat | f3.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mass_reg   <= mass_next;
        xmom_reg   <= xmom_next;
        ymom_reg   <= ymom_next;
        energy_reg <= energy_next;
        bad_reg    <= bad_next;
        sat_reg    <= sat_next;
    end

    assign done        = done_reg;
    assign mass_flux   = mass_reg;
    assign xmom_flux   = xmom_reg;
    assign ymom_flux   = ymom_reg;
    assign energy_flux = energy_reg;
    assign bad_density = bad_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire
